// ===== rtl/ptpd_pkg.sv =====
// ptpd_pkg: shared widths, register indexes and reset values for the
// PID temperature-to-PWM block. No dependencies.
package ptpd_pkg;

  // Field widths
  localparam int TempW  = 16;
  localparam int ErrW   = 17;
  localparam int GainW  = 24;
  localparam int MapW   = 16;
  localparam int PidW   = 32;
  localparam int IntegW = 40;
  localparam int InDataW  = 16;
  localparam int OutDataW = 56;  // 16 + 32 + 1 = 49 bits, padded to 7 bytes
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // Shared multiplier operand / product widths
  localparam int MulAW = 25;
  localparam int MulBW = 22;
  localparam int MulPW = MulAW + MulBW;

  // Divide-by-20 unit: 64-bit dividend, one byte of quotient per step
  localparam int DivW      = 64;
  localparam int DivStepW  = 8;
  localparam int DivRemW   = 5;
  localparam int DivCntW   = 3;
  localparam int DivRecipW = 12;
  localparam logic [DivRecipW-1:0] DivRecip = 12'd3277;  // ceil(2^16 / 20)
  localparam int DivRecipShift = 16;
  localparam logic [DivRemW-1:0] DivConst = 5'd20;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSetpoint  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainProp  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainInteg = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainDeriv = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMapSlope  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMapOffset = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPwmPeriod = 3'd6;

  // Reset values
  localparam logic [TempW-1:0] SetpointRst  = 16'd15360;   // 60.0
  localparam logic [GainW-1:0] GainPropRst  = 24'd327680;  // 5.0
  localparam logic [GainW-1:0] GainIntegRst = 24'd1966;    // ~0.03
  localparam logic [GainW-1:0] GainDerivRst = 24'd196608;  // 3.0
  localparam logic [MapW-1:0]  MapSlopeRst  = 16'd36659;
  localparam logic [MapW-1:0]  MapOffsetRst = 16'hF115;    // -3819
  localparam logic [MapW-1:0]  PwmPeriodRst = 16'd10000;

endpackage

// ===== rtl/ptpd_mul.sv =====
// ptpd_mul: shared signed multiplier with registered product.
// Depends on ptpd_pkg.
module ptpd_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [ptpd_pkg::MulAW-1:0]   a_i,
  input  logic signed [ptpd_pkg::MulBW-1:0]   b_i,
  output logic signed [ptpd_pkg::MulPW-1:0]   prod_o
);
  import ptpd_pkg::*;

  logic signed [MulPW-1:0] prod_q, prod_d;

  assign prod_d = MulPW'(a_i) * MulPW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/ptpd_div20.sv =====
// ptpd_div20: iterative unsigned divide by 20, one quotient byte per cycle.
// Depends on ptpd_pkg.
module ptpd_div20 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ptpd_pkg::DivW-1:0]     dividend_i,
  output logic                          busy_o,
  output logic [ptpd_pkg::DivW-1:0]     quot_o
);
  import ptpd_pkg::*;

  localparam int VW = DivRemW + DivStepW;
  localparam int RW = VW + DivRecipW;

  logic [DivW-1:0]    sh_q, sh_d;
  logic [DivRemW-1:0] rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;

  logic [VW-1:0]       val;
  logic [RW-1:0]       recip_prod;
  logic [DivStepW-1:0] qdig;
  logic [VW-1:0]       back;

  // reciprocal estimate is exact for val < 20 * 256
  assign val        = {rem_q, sh_q[DivW-1 -: DivStepW]};
  assign recip_prod = RW'(val) * RW'(DivRecip);
  assign qdig       = recip_prod[DivRecipShift +: DivStepW];
  assign back       = VW'(qdig) * VW'(DivConst);

  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      sh_d   = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d  = {sh_q[DivW-DivStepW-1:0], qdig};
      rem_d = DivRemW'(val - back);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign quot_o = sh_q;

endmodule

// ===== rtl/pid_temperature_to_pwm_duty.sv =====
// pid_temperature_to_pwm_duty: discrete PID controller, temperature in, PWM duty out.
// Depends on ptpd_pkg, ptpd_mul, ptpd_div20.
//
// Usage:
//  - Slave stream takes one signed Q8.8 temperature per transfer (tdata[15:0]).
//  - Master stream gives one result per sample: duty, saturated Q.8 PID value
//    and the error-positive flag, packed in tdata.
//  - Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//    (0 setpoint, 1..3 P/I/D gains, 4 map slope, 5 map offset, 6 PWM period);
//    index 7 is ignored. Write only while the block is idle.
//  - One sample at a time: the sequencer walks six products through the
//    single multiplier plus eight steps of the divide-by-20 unit.
//  - s_axis_tready is high only while the sequencer is idle.
//  - A finished result sits in the output register; the next sample is
//    accepted while it waits. If the receiver stalls, the sequencer holds the
//    following result in its last state until the output register frees up.
//  - Reset restores the register defaults, clears the integrator and previous
//    error, and makes the first sample after reset seed the previous error.
module pid_temperature_to_pwm_duty (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: [15:0] temperature
  input  logic [ptpd_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: [15:0] duty, [47:16] pid_value, [48] error_positive, [55:49] zero
  output logic [ptpd_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_we_i,
  input  logic [ptpd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ptpd_pkg::CfgDataW-1:0]    cfg_data_i
);
  import ptpd_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;   // integrator update, derivative operand
  localparam logic [3:0] S_MAG  = 4'd2;   // issue kp*e, take |acc|
  localparam logic [3:0] S_MD   = 4'd3;   // issue kd*(de*10), add P
  localparam logic [3:0] S_MIL  = 4'd4;   // issue ki*|acc|lo, add D
  localparam logic [3:0] S_MIH  = 4'd5;   // issue ki*|acc|hi, keep lo product
  localparam logic [3:0] S_IADD = 4'd6;   // combine halves, start divide
  localparam logic [3:0] S_DIV  = 4'd7;   // wait for divide, add signed I
  localparam logic [3:0] S_RND  = 4'd8;   // round to Q.8, saturate
  localparam logic [3:0] S_MLO  = 4'd9;   // issue slope*pid[15:0]
  localparam logic [3:0] S_MHI  = 4'd10;  // issue slope*pid[31:16], offset + lo
  localparam logic [3:0] S_YADD = 4'd11;  // add hi product
  localparam logic [3:0] S_OUT  = 4'd12;  // clamp, load output register

  localparam int SumW  = 64;
  localparam int YW    = 50;
  localparam int HalfW = IntegW / 2;
  localparam int IProdW = GainW + HalfW;

  // configuration registers
  logic [TempW-1:0] setpoint_q;
  logic [GainW-1:0] kp_q, ki_q, kd_q;
  logic [MapW-1:0]  slope_q, offset_q, period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= SetpointRst;
      kp_q       <= GainPropRst;
      ki_q       <= GainIntegRst;
      kd_q       <= GainDerivRst;
      slope_q    <= MapSlopeRst;
      offset_q   <= MapOffsetRst;
      period_q   <= PwmPeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSetpoint:  setpoint_q <= cfg_data_i[TempW-1:0];
        RegGainProp:  kp_q       <= cfg_data_i[GainW-1:0];
        RegGainInteg: ki_q       <= cfg_data_i[GainW-1:0];
        RegGainDeriv: kd_q       <= cfg_data_i[GainW-1:0];
        RegMapSlope:  slope_q    <= cfg_data_i[MapW-1:0];
        RegMapOffset: offset_q   <= cfg_data_i[MapW-1:0];
        RegPwmPeriod: period_q   <= cfg_data_i[MapW-1:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [3:0]        state_q, state_d;
  logic              primed_q;
  logic [ErrW-1:0]   prev_q;
  logic [IntegW-1:0] integ_q;
  logic              m_valid_q;

  // datapath registers
  logic [ErrW-1:0]    e_q, ep_q;
  logic [MulBW-1:0]   dop_q;
  logic [IntegW-1:0]  mag_q;
  logic [SumW-1:0]    sum_q;
  logic [IProdW-1:0]  ilo_q;
  logic [PidW-1:0]    pid_q;
  logic [YW-1:0]      y_q;
  logic [MapW-1:0]    duty_q;
  logic [PidW-1:0]    pid_out_q;
  logic               epos_q;

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // error and previous error at accept
  logic [ErrW-1:0] e_new;
  assign e_new = {setpoint_q[TempW-1], setpoint_q} - {s_axis_tdata[TempW-1], s_axis_tdata};

  // integrator update, saturating at 40 bits
  logic [ErrW:0]     epair, ediff;
  logic [IntegW:0]   acc_wide;
  logic [IntegW-1:0] acc_sat;
  assign epair    = {e_q[ErrW-1], e_q} + {ep_q[ErrW-1], ep_q};
  assign ediff    = {e_q[ErrW-1], e_q} - {ep_q[ErrW-1], ep_q};
  assign acc_wide = {integ_q[IntegW-1], integ_q}
                  + {{(IntegW-ErrW){epair[ErrW]}}, epair};
  always_comb begin
    if (acc_wide[IntegW] != acc_wide[IntegW-1]) begin
      acc_sat = acc_wide[IntegW] ? {1'b1, {(IntegW-1){1'b0}}} : {1'b0, {(IntegW-1){1'b1}}};
    end else begin
      acc_sat = acc_wide[IntegW-1:0];
    end
  end

  // de*10 = de*8 + de*2
  logic [MulBW-1:0] dop_new;
  assign dop_new = {ediff[ErrW], ediff, 3'b000} + {{3{ediff[ErrW]}}, ediff, 1'b0};

  // shared multiplier
  logic                    mul_en;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] prod;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_MAG: begin
        mul_a = {1'b0, kp_q};
        mul_b = {{(MulBW-ErrW){e_q[ErrW-1]}}, e_q};
      end
      S_MD: begin
        mul_a = {1'b0, kd_q};
        mul_b = dop_q;
      end
      S_MIL: begin
        mul_a = {1'b0, ki_q};
        mul_b = {{(MulBW-HalfW){1'b0}}, mag_q[HalfW-1:0]};
      end
      S_MIH: begin
        mul_a = {1'b0, ki_q};
        mul_b = {{(MulBW-HalfW){1'b0}}, mag_q[IntegW-1:HalfW]};
      end
      S_MLO: begin
        mul_a = {{(MulAW-MapW){1'b0}}, slope_q};
        mul_b = {{(MulBW-16){1'b0}}, pid_q[15:0]};
      end
      S_MHI: begin
        mul_a = {{(MulAW-MapW){1'b0}}, slope_q};
        mul_b = {{(MulBW-16){pid_q[PidW-1]}}, pid_q[PidW-1:16]};
      end
      default: mul_en = 1'b0;
    endcase
  end

  ptpd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // ki*|acc| = lo + hi<<20, then divided by 20
  logic            div_start, div_busy;
  logic [DivW-1:0] div_dividend, quot;
  assign div_start    = (state_q == S_IADD);
  assign div_dividend = {{(DivW-IProdW){1'b0}}, ilo_q}
                      + {prod[IProdW-1:0], {HalfW{1'b0}}};

  ptpd_div20 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  logic [SumW-1:0] prod_ext, iterm;
  assign prod_ext = {{(SumW-MulPW){prod[MulPW-1]}}, prod};
  assign iterm    = integ_q[IntegW-1] ? (~quot + 1'b1) : quot;

  // round half up to Q.8, saturate to 32 bits
  logic [SumW-1:0] rnd;
  logic [PidW-1:0] pid_sat;
  assign rnd = sum_q + SumW'(32768);
  always_comb begin
    if (rnd[SumW-1:16+PidW-1] != {(SumW-16-PidW+1){rnd[SumW-1]}}) begin
      pid_sat = rnd[SumW-1] ? {1'b1, {(PidW-1){1'b0}}} : {1'b0, {(PidW-1){1'b1}}};
    end else begin
      pid_sat = rnd[16 +: PidW];
    end
  end

  // duty clamp
  logic [MapW-1:0] duty_new;
  always_comb begin
    if (y_q[YW-1]) begin
      duty_new = '0;
    end else if (y_q[YW-2:0] >= {{(YW-1-2*MapW){1'b0}}, period_q, {MapW{1'b0}}}) begin
      duty_new = period_q;
    end else begin
      duty_new = y_q[2*MapW-1:MapW];
    end
  end

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_ACC;
      S_ACC:  state_d = S_MAG;
      S_MAG:  state_d = S_MD;
      S_MD:   state_d = S_MIL;
      S_MIL:  state_d = S_MIH;
      S_MIH:  state_d = S_IADD;
      S_IADD: state_d = S_DIV;
      S_DIV:  if (!div_busy) state_d = S_RND;
      S_RND:  state_d = S_MLO;
      S_MLO:  state_d = S_MHI;
      S_MHI:  state_d = S_YADD;
      S_YADD: state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      primed_q  <= 1'b0;
      prev_q    <= '0;
      integ_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        primed_q <= 1'b1;
      end
      if (state_q == S_ACC) begin
        integ_q <= acc_sat;
        prev_q  <= e_q;
      end
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      e_q  <= e_new;
      ep_q <= primed_q ? prev_q : e_new;  // first sample seeds previous error
    end
    case (state_q)
      S_ACC:  dop_q <= dop_new;
      S_MAG: begin
        mag_q <= integ_q[IntegW-1] ? (~integ_q + 1'b1) : integ_q;
        sum_q <= '0;
      end
      S_MD:   sum_q <= sum_q + prod_ext;
      S_MIL:  sum_q <= sum_q + prod_ext;
      S_MIH:  ilo_q <= prod[IProdW-1:0];
      S_DIV:  if (!div_busy) sum_q <= sum_q + iterm;
      S_RND:  pid_q <= pid_sat;
      S_MHI:  y_q <= {{(YW-2*MapW){offset_q[MapW-1]}}, offset_q, {MapW{1'b0}}}
                   + {{(YW-2*MapW){1'b0}}, prod[2*MapW-1:0]};
      S_YADD: y_q <= y_q + {prod[YW-MapW-1:0], {MapW{1'b0}}};
      S_OUT: begin
        if (out_free) begin
          duty_q    <= duty_new;
          pid_out_q <= pid_q;
          epos_q    <= !e_q[ErrW-1] && (e_q != '0);
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW-MapW-PidW-1){1'b0}}, epos_q, pid_out_q, duty_q};

endmodule

// ===== rtl/ptpd_chk.sv =====
// ptpd_chk: port-level checks for pid_temperature_to_pwm_duty, bound to the top.
// Depends on ptpd_pkg.
module ptpd_chk (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [ptpd_pkg::OutDataW-1:0]    m_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready
);
  import ptpd_pkg::*;

  // one sample at a time: busy right after a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ptpd: accepted a sample while busy");

  // a new result appears only as the sequencer returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("ptpd: result loaded while sequencer busy");

  // no result directly after a sample is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("ptpd: result appeared too early");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("ptpd: stalled result changed");

endmodule

bind pid_temperature_to_pwm_duty ptpd_chk u_ptpd_chk (.*);
